// ----- rtl/core/aww_pkg.sv -----
// shared constants, codes and control types of the automaton word walker
`timescale 1ns / 1ps

package aww_pkg;

    // table sizes
    localparam int MAX_NODES = 4096;
    localparam int MAX_EDGES = 16384;

    // field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 14;
    localparam int OFFS_W  = 15;
    localparam int SYM_W   = 8;
    localparam int NODE_W  = 12;
    localparam int STAT_W  = 2;

    // derived widths
    localparam int NODE_ADDR_W = $clog2(MAX_NODES + 1);
    localparam int EDGE_ADDR_W = $clog2(MAX_EDGES);
    localparam int EDGE_CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int NODE_RAM_W  = OFFS_W + 1;
    localparam int EDGE_RAM_W  = SYM_W + NODE_W;

    // word opcodes
    typedef enum logic [OP_W-1:0] {
        OP_NODE_WR = 2'd0,
        OP_EDGE_WR = 2'd1,
        OP_STEP    = 2'd2,
        OP_RESTART = 2'd3
    } t_opcode;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_MOVED     = 2'd0,
        ST_NO_MOVE   = 2'd1,
        ST_WRITTEN   = 2'd2,
        ST_RESTARTED = 2'd3
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic accept;        // input word taken this cycle
        logic node_rd_next;  // node table read at current node + 1
        logic ld_lo;         // capture clamped first edge
        logic ld_end;        // capture clamped end of run
        logic ld_mid;        // capture probe address
        logic probe_upd;     // narrow search window from probed label
        logic edge_rd_lo;    // edge table read at lower bound
        logic take;          // move to the found edge's target
        logic miss;          // walk dies
        logic load_out;      // fill output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic walk_in;   // incoming word is a step on a live walk
        logic end_ok;    // run is not empty
        logic lo_lt_hi;  // search window open
        logic lo_lt_end; // lower bound inside the run
        logic label_eq;  // edge label equals symbol
    } t_stat;

    // clamp an offset to the edge table size
    function automatic logic [EDGE_CNT_W-1:0] clamp_edge(input logic [OFFS_W-1:0] v);
        if (32'(v) > 32'(MAX_EDGES)) begin
            return EDGE_CNT_W'(MAX_EDGES);
        end
        return EDGE_CNT_W'(v);
    endfunction

endpackage

// ----- rtl/core/aww_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module aww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/aww_datapath.sv -----
// walker datapath: tables, search window, walk state and output register
`timescale 1ns / 1ps

module aww_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  aww_pkg::t_cmd             i_cmd,
    output aww_pkg::t_stat            o_stat,
    input  logic                      i_cfg_we,
    input  logic [aww_pkg::NODE_W-1:0] i_cfg_wdata,
    input  logic [aww_pkg::OP_W-1:0]  i_opcode,
    input  logic [aww_pkg::IDX_W-1:0] i_table_index,
    input  logic [aww_pkg::OFFS_W-1:0] i_first_edge,
    input  logic                      i_is_final,
    input  logic [aww_pkg::SYM_W-1:0] i_symbol,
    input  logic [aww_pkg::NODE_W-1:0] i_target_node,
    output logic [aww_pkg::STAT_W-1:0] o_status,
    output logic [aww_pkg::NODE_W-1:0] o_node_now,
    output logic                      o_accepting
);

    import aww_pkg::*;

    logic [NODE_W-1:0]      r_start;
    logic [NODE_W-1:0]      r_cur;
    logic                   r_dead;
    t_status                r_status;
    logic [SYM_W-1:0]       r_sym;
    logic [EDGE_CNT_W-1:0]  r_lo;
    logic [EDGE_CNT_W-1:0]  r_hi;
    logic [EDGE_CNT_W-1:0]  r_end;
    logic [EDGE_CNT_W-1:0]  r_mid;
    logic [STAT_W-1:0]      r_out_status;
    logic [NODE_W-1:0]      r_out_node;
    logic                   r_out_acc;

    logic [EDGE_CNT_W-1:0]  mid;
    logic [EDGE_CNT_W-1:0]  run_end;
    logic                   node_we;
    logic                   edge_we;
    logic [NODE_ADDR_W-1:0] node_raddr;
    logic [EDGE_ADDR_W-1:0] edge_raddr;
    logic [NODE_RAM_W-1:0]  node_rdata;
    logic [EDGE_RAM_W-1:0]  edge_rdata;
    logic [SYM_W-1:0]       edge_label;
    logic [NODE_W-1:0]      edge_target;

    // table write enables straight from the accepted word
    assign node_we = i_cmd.accept && (t_opcode'(i_opcode) == OP_NODE_WR)
                     && (32'(i_table_index) <= 32'(MAX_NODES));
    assign edge_we = i_cmd.accept && (t_opcode'(i_opcode) == OP_EDGE_WR)
                     && (32'(i_table_index) < 32'(MAX_EDGES));

    // read addresses
    assign node_raddr = i_cmd.node_rd_next ? (NODE_ADDR_W'(r_cur) + NODE_ADDR_W'(1))
                                           : NODE_ADDR_W'(r_cur);
    assign mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign edge_raddr = i_cmd.edge_rd_lo ? r_lo[EDGE_ADDR_W-1:0] : mid[EDGE_ADDR_W-1:0];

    // node table: terminal flag over first edge offset
    aww_ram #(
        .WIDTH (NODE_RAM_W),
        .DEPTH (MAX_NODES + 1)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (i_table_index[NODE_ADDR_W-1:0]),
        .i_wdata ({i_is_final, i_first_edge}),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // edge table: label over target node
    aww_ram #(
        .WIDTH (EDGE_RAM_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (i_table_index[EDGE_ADDR_W-1:0]),
        .i_wdata ({i_symbol, i_target_node}),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    assign edge_label  = edge_rdata[EDGE_RAM_W-1:NODE_W];
    assign edge_target = edge_rdata[NODE_W-1:0];
    assign run_end     = clamp_edge(node_rdata[OFFS_W-1:0]);

    // status toward the controller
    assign o_stat.walk_in   = (t_opcode'(i_opcode) == OP_STEP) && !r_dead;
    assign o_stat.end_ok    = r_lo < run_end;
    assign o_stat.lo_lt_hi  = r_lo < r_hi;
    assign o_stat.lo_lt_end = r_lo < r_end;
    assign o_stat.label_eq  = edge_label == r_sym;

    // walk state and start register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_cur   <= '0;
            r_dead  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            if (i_cmd.accept && (t_opcode'(i_opcode) == OP_RESTART)) begin
                r_cur  <= r_start;
                r_dead <= 1'b0;
            end
            if (i_cmd.take) begin
                r_cur <= edge_target;
            end
            if (i_cmd.miss) begin
                r_dead <= 1'b1;
            end
        end
    end

    // word latch, search window and result status
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sym <= i_symbol;
            case (t_opcode'(i_opcode))
                OP_NODE_WR: r_status <= ST_WRITTEN;
                OP_EDGE_WR: r_status <= ST_WRITTEN;
                OP_RESTART: r_status <= ST_RESTARTED;
                OP_STEP:    r_status <= r_dead ? ST_NO_MOVE : ST_MOVED;
                default:    r_status <= ST_NO_MOVE;
            endcase
        end
        if (i_cmd.miss) begin
            r_status <= ST_NO_MOVE;
        end
        if (i_cmd.ld_lo) begin
            r_lo <= run_end;
        end
        if (i_cmd.ld_end) begin
            r_end <= run_end;
            r_hi  <= run_end;
        end
        if (i_cmd.ld_mid) begin
            r_mid <= mid;
        end
        if (i_cmd.probe_upd) begin
            if (edge_label < r_sym) begin
                r_lo <= r_mid + EDGE_CNT_W'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_node   <= r_cur;
            r_out_acc    <= r_dead ? 1'b0 : node_rdata[OFFS_W];
        end
    end

    assign o_status    = r_out_status;
    assign o_node_now  = r_out_node;
    assign o_accepting = r_out_acc;

endmodule

// ----- rtl/core/aww_ctrl.sv -----
// walker controller: sequences table reads and the binary search per word
`timescale 1ns / 1ps

module aww_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  aww_pkg::t_stat i_stat,
    output aww_pkg::t_cmd  o_cmd
);

    import aww_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NODE_LO,
        S_NODE_HI,
        S_NODE_END,
        S_PROBE,
        S_PROBE_CMP,
        S_FINAL_RD,
        S_FINAL_CMP,
        S_FLAG_RD,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.walk_in ? S_NODE_LO : S_FLAG_RD;
                end
            end
            S_NODE_LO: begin
                n_state = S_NODE_HI;
            end
            S_NODE_HI: begin
                o_cmd.node_rd_next = 1'b1;
                o_cmd.ld_lo = 1'b1;
                n_state = S_NODE_END;
            end
            S_NODE_END: begin
                o_cmd.ld_end = 1'b1;
                if (i_stat.end_ok) begin
                    n_state = S_PROBE;
                end else begin
                    o_cmd.miss = 1'b1;
                    n_state = S_FLAG_RD;
                end
            end
            S_PROBE: begin
                if (i_stat.lo_lt_hi) begin
                    o_cmd.ld_mid = 1'b1;
                    n_state = S_PROBE_CMP;
                end else begin
                    n_state = S_FINAL_RD;
                end
            end
            S_PROBE_CMP: begin
                o_cmd.probe_upd = 1'b1;
                n_state = S_PROBE;
            end
            S_FINAL_RD: begin
                o_cmd.edge_rd_lo = 1'b1;
                if (i_stat.lo_lt_end) begin
                    n_state = S_FINAL_CMP;
                end else begin
                    o_cmd.miss = 1'b1;
                    n_state = S_FLAG_RD;
                end
            end
            S_FINAL_CMP: begin
                if (i_stat.label_eq) begin
                    o_cmd.take = 1'b1;
                end else begin
                    o_cmd.miss = 1'b1;
                end
                n_state = S_FLAG_RD;
            end
            S_FLAG_RD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/automaton_word_walker.sv -----
// top level of the dictionary automaton word walker
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  cfg     | in        | i_cfg_we                   | i_cfg_wdata (start node)
//  in      | in        | i_in_valid / o_in_stall    | opcode, table_index, first_edge,
//          |           |                            | is_final, symbol, target_node
//  out     | out       | o_out_valid / i_out_stall  | status, node_now, accepting
//
// one word at a time. table writes, restarts and steps on a dead walk skip the search.
// a step makes p binary search probes, p up to floor(log2(run)) + 1 and so at most 15:
// each probe is an address and a compare state on the edge ram read port.
// a step whose search ends past the run skips the final compare, a step on an empty run the search.
// the offset pair and the terminal flag come from one node ram read port, in turn.
// synchronous active-low reset; tables hold no reset value and need no clearing pass.
// a new word is taken while the previous word still waits in the output register.
`timescale 1ns / 1ps

module automaton_word_walker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [aww_pkg::NODE_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [aww_pkg::OP_W-1:0]   i_opcode,
    input  logic [aww_pkg::IDX_W-1:0]  i_table_index,
    input  logic [aww_pkg::OFFS_W-1:0] i_first_edge,
    input  logic                       i_is_final,
    input  logic [aww_pkg::SYM_W-1:0]  i_symbol,
    input  logic [aww_pkg::NODE_W-1:0] i_target_node,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [aww_pkg::STAT_W-1:0] o_status,
    output logic [aww_pkg::NODE_W-1:0] o_node_now,
    output logic                       o_accepting
);

    import aww_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    aww_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // tables and walk state
    aww_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_opcode      (i_opcode),
        .i_table_index (i_table_index),
        .i_first_edge  (i_first_edge),
        .i_is_final    (i_is_final),
        .i_symbol      (i_symbol),
        .i_target_node (i_target_node),
        .o_status      (o_status),
        .o_node_now    (o_node_now),
        .o_accepting   (o_accepting)
    );

endmodule
